@@ src/g711_pkg.sv @@
// Shared types and constants for the G.711 PCM slot converter.
`default_nettype none

package g711_pkg;

  localparam int CHANNELS_DEF = 4;

  // Per-channel codec mode codes; any other code is treated as A-law
  localparam logic [1:0] MODE_LINEAR = 2'd0;
  localparam logic [1:0] MODE_ULAW   = 2'd1;

  // Input actions
  localparam logic ACT_TX = 1'b0;
  localparam logic ACT_RX = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_CODEC_MODES = 2'd0;
  localparam logic [1:0] REG_TX_HIGH     = 2'd1;
  localparam logic [1:0] REG_RX_SWAP     = 2'd2;

  localparam logic [7:0] BYTE_ZERO = 8'h00;

  typedef struct packed {
    logic       action;
    logic [2:0] channel;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
  } pcm_in_t;

  typedef struct packed {
    logic [7:0] out_first_byte;
    logic [7:0] out_second_byte;
  } pcm_out_t;

endpackage

`default_nettype wire

@@ src/g711_pcm_slot_converter.sv @@
// Throughput: one item per cycle while out_stall is low; three register stages
// (magnitude, segment, code/linear assembly) each hold one item and advance
// independently, and an accepted input item passes through all three to the output.
// Reset (rst, synchronous): empties all stages and clears codec_modes,
// tx_code_high_mask and rx_swap_bytes to zero. Config writes are always ready.
`default_nettype none

module g711_pcm_slot_converter
  import g711_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire pcm_in_t     in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output pcm_out_t         out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam logic [3:0] ChanLimit = 4'(CHANNELS);

  // Bit length of an 8-bit value (0 for zero, 8 when the top bit is set)
  function automatic logic [3:0] bit_len8(input logic [7:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 8; i++) begin
      if (v[i]) n = 4'(i + 1);
    end
    return n;
  endfunction

  // Configuration registers
  logic [15:0] codec_modes;
  logic [7:0]  tx_code_high_mask;
  logic        rx_swap_bytes;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      codec_modes       <= '0;
      tx_code_high_mask <= '0;
      rx_swap_bytes     <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CODEC_MODES: codec_modes       <= cfg_data;
        REG_TX_HIGH:     tx_code_high_mask <= cfg_data[7:0];
        REG_RX_SWAP:     rx_swap_bytes     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Stage handshake
  logic v1, v2, v3;
  logic adv1, adv2, adv3;

  assign adv3     = !v3 || !out_stall;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign in_stall = !adv1;
  assign out_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
  end

  // Front logic: mode lookup, encoder magnitudes, decoder base values
  logic [1:0]  mode_bits;
  logic        in_range;
  logic        f_lin;
  logic        f_ulaw;
  logic [15:0] w;
  logic [16:0] neg_mag17;
  logic [14:0] mu_raw;
  logic [14:0] mu_clip;
  logic [13:0] mu_mag;
  logic [12:0] a_mag;
  logic [7:0]  f_emask;
  logic [15:0] f_lin_word;
  logic [7:0]  u_code;
  logic [7:0]  a_code;
  logic [8:0]  f_dbase;
  logic [2:0]  f_dsh;
  logic        f_dneg;
  logic [15:0] f_doff;

  always_comb begin
    mode_bits = codec_modes[{in_data.channel, 1'b0} +: 2];
    in_range  = {1'b0, in_data.channel} < ChanLimit;
    f_lin     = !in_range || (mode_bits == MODE_LINEAR);
    f_ulaw    = !f_lin && (mode_bits == MODE_ULAW);
    w         = {in_data.second_byte, in_data.first_byte};

    // mu-law: magnitude of floor(x/4), clipped, plus bias
    neg_mag17 = 17'h10003 - {1'b0, w};
    mu_raw    = w[15] ? neg_mag17[16:2] : {1'b0, w[15:2]};
    mu_clip   = (mu_raw > 15'd8159) ? 15'd8159 : mu_raw;
    mu_mag    = 14'(mu_clip + 15'd33);
    // A-law: ones' complement magnitude of x/8
    a_mag     = w[15] ? ~w[15:3] : w[15:3];

    if (f_ulaw) f_emask = w[15] ? 8'h7f : 8'hff;
    else        f_emask = w[15] ? 8'h55 : 8'hd5;

    if (in_data.action == ACT_RX && rx_swap_bytes) begin
      f_lin_word = {in_data.first_byte, in_data.second_byte};
    end else begin
      f_lin_word = {in_data.second_byte, in_data.first_byte};
    end

    // Decode setup: result = (neg ? off - t : t + off), t = base << sh
    u_code = ~in_data.first_byte;
    a_code = in_data.first_byte ^ 8'h55;
    if (f_ulaw) begin
      f_dbase = 9'({u_code[3:0], 3'b000}) + 9'h084;
      f_dsh   = u_code[6:4];
      f_dneg  = u_code[7];
      f_doff  = u_code[7] ? 16'h0084 : 16'hff7c;
    end else begin
      if (a_code[6:4] == 3'd0) begin
        f_dbase = 9'({a_code[3:0], 4'b0000}) + 9'h008;
        f_dsh   = 3'd0;
      end else begin
        f_dbase = 9'({a_code[3:0], 4'b0000}) + 9'h108;
        f_dsh   = a_code[6:4] - 3'd1;
      end
      f_dneg = !a_code[7];
      f_doff = 16'h0000;
    end
  end

  // Stage 1 registers
  logic        s1_action, s1_lin, s1_ulaw, s1_hi;
  logic [15:0] s1_lin_word;
  logic [13:0] s1_mag;
  logic [7:0]  s1_emask;
  logic [8:0]  s1_dbase;
  logic [2:0]  s1_dsh;
  logic        s1_dneg;
  logic [15:0] s1_doff;

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      s1_action   <= in_data.action;
      s1_lin      <= f_lin;
      s1_ulaw     <= f_ulaw;
      s1_hi       <= tx_code_high_mask[in_data.channel];
      s1_lin_word <= f_lin_word;
      s1_mag      <= f_ulaw ? mu_mag : {1'b0, a_mag};
      s1_emask    <= f_emask;
      s1_dbase    <= f_dbase;
      s1_dsh      <= f_dsh;
      s1_dneg     <= f_dneg;
      s1_doff     <= f_doff;
    end
  end

  // Stage 2: segment search, mantissa shift amount, decoder shift
  logic [3:0]  seg_next;
  logic [3:0]  sh_next;
  logic [15:0] dt_next;

  always_comb begin
    seg_next = bit_len8(s1_ulaw ? s1_mag[13:6] : s1_mag[12:5]);
    if (s1_ulaw)             sh_next = seg_next + 4'd1;
    else if (seg_next < 4'd2) sh_next = 4'd1;
    else                     sh_next = seg_next;
    dt_next = 16'({7'b0, s1_dbase} << s1_dsh);
  end

  logic        s2_action, s2_lin, s2_hi;
  logic [15:0] s2_lin_word;
  logic [13:0] s2_mag;
  logic [7:0]  s2_emask;
  logic [3:0]  s2_seg;
  logic [3:0]  s2_sh;
  logic [15:0] s2_dt;
  logic        s2_dneg;
  logic [15:0] s2_doff;

  always_ff @(posedge clk) begin
    if (adv2 && v1) begin
      s2_action   <= s1_action;
      s2_lin      <= s1_lin;
      s2_hi       <= s1_hi;
      s2_lin_word <= s1_lin_word;
      s2_mag      <= s1_mag;
      s2_emask    <= s1_emask;
      s2_seg      <= seg_next;
      s2_sh       <= sh_next;
      s2_dt       <= dt_next;
      s2_dneg     <= s1_dneg;
      s2_doff     <= s1_doff;
    end
  end

  // Stage 3: assemble code or linear sample
  logic [3:0]  mant;
  logic [7:0]  code;
  logic [15:0] dec;
  pcm_out_t    res_next;

  always_comb begin
    mant = 4'(s2_mag >> s2_sh);
    if (s2_seg[3]) code = 8'h7f ^ s2_emask;
    else           code = {1'b0, s2_seg[2:0], mant} ^ s2_emask;
    dec = s2_dneg ? (s2_doff - s2_dt) : (s2_dt + s2_doff);

    if (s2_lin) begin
      res_next.out_first_byte  = s2_lin_word[7:0];
      res_next.out_second_byte = s2_lin_word[15:8];
    end else if (s2_action == ACT_RX) begin
      res_next.out_first_byte  = dec[7:0];
      res_next.out_second_byte = dec[15:8];
    end else if (s2_hi) begin
      res_next.out_first_byte  = BYTE_ZERO;
      res_next.out_second_byte = code;
    end else begin
      res_next.out_first_byte  = code;
      res_next.out_second_byte = BYTE_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && v2) begin
      out_data <= res_next;
    end
  end

endmodule

`default_nettype wire

@@ dv/g711_pcm_slot_converter_test.sv @@
// Self-checking testbench for the G.711 PCM slot converter with its own predictor.
module g711_pcm_slot_converter_test;
  import g711_pkg::*;

  localparam int NUM_CH = CHANNELS_DEF;
  localparam int HOLD_CYCLES = 120;
  localparam int RAND_PER_SETTING = 34;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam pcm_out_t NO_WANT = '0;

  typedef struct packed {
    logic [15:0] modes;
    logic [7:0]  tx_high;
    logic        swap;
    pcm_in_t     item;
    logic        fixed;
    pcm_out_t    want;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  pcm_in_t     in_data;
  logic        out_valid;
  logic        out_stall;
  pcm_out_t    out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  // Local copy of the register file
  logic [15:0] mdl_modes;
  logic [7:0]  mdl_tx_high;
  logic        mdl_swap;

  pcm_out_t pending_slots[$];
  int tx_idle_pct;
  int rx_idle_pct;
  bit hold_off_req;
  int n_sent, n_directed, n_checked, n_cfg, n_fail;

  g711_pcm_slot_converter dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Segment: first s whose bound (top << s, low bits filled) covers mag, else 8
  function automatic int unsigned seg_find(input int unsigned mag, input int unsigned top);
    for (int s = 0; s < 8; s++) begin
      if (mag <= ((top << s) | ((32'd1 << s) - 1))) return s;
    end
    return 8;
  endfunction

  function automatic logic [7:0] ulaw_code(input logic [15:0] w);
    int unsigned mag;
    int unsigned seg;
    logic [7:0] flip;
    if (w[15]) begin
      mag = (32'h1_0000 - {16'h0, w} + 32'd3) >> 2;
      flip = 8'h7f;
    end else begin
      mag = {16'h0, w} >> 2;
      flip = 8'hff;
    end
    if (mag > 8159) mag = 8159;
    mag += 33;
    seg = seg_find(mag, 32'h3f);
    if (seg >= 8) return 8'h7f ^ flip;
    return 8'((seg << 4) | ((mag >> (seg + 1)) & 32'hf)) ^ flip;
  endfunction

  function automatic logic [7:0] alaw_code(input logic [15:0] w);
    int unsigned mag;
    int unsigned seg;
    int unsigned code;
    logic [15:0] inv;
    logic [7:0] flip;
    inv = ~w;
    if (w[15]) begin
      mag = {16'h0, inv} >> 3;
      flip = 8'h55;
    end else begin
      mag = {16'h0, w} >> 3;
      flip = 8'hd5;
    end
    seg = seg_find(mag, 32'h1f);
    if (seg >= 8) return 8'h7f ^ flip;
    code = seg << 4;
    if (seg < 2) code |= (mag >> 1) & 32'hf;
    else code |= (mag >> seg) & 32'hf;
    return 8'(code) ^ flip;
  endfunction

  function automatic logic [15:0] ulaw_linear(input logic [7:0] c);
    logic [7:0] u;
    int unsigned t;
    u = ~c;
    t = ((32'(u[3:0]) << 3) + 32'h84) << u[6:4];
    if (u[7]) return 16'(32'h84 - t);
    return 16'(t - 32'h84);
  endfunction

  function automatic logic [15:0] alaw_linear(input logic [7:0] c);
    logic [7:0] a;
    int unsigned t;
    int unsigned seg;
    a = c ^ 8'h55;
    t = 32'(a[3:0]) << 4;
    seg = 32'(a[6:4]);
    if (seg == 0) t += 8;
    else t = (t + 32'h108) << (seg - 1);
    if (a[7]) return 16'(t);
    return 16'(32'd0 - t);
  endfunction

  function automatic pcm_out_t convert_sample(input pcm_in_t it);
    logic [1:0]  mode;
    logic [15:0] w;
    logic [15:0] lin;
    logic [7:0]  code;
    pcm_out_t    r;
    mode = MODE_LINEAR;
    if (it.channel < NUM_CH) mode = mdl_modes[2*it.channel +: 2];
    w = {it.second_byte, it.first_byte};
    if (it.action == ACT_TX) begin
      if (mode == MODE_LINEAR) begin
        r = '{it.first_byte, it.second_byte};
      end else begin
        code = (mode == MODE_ULAW) ? ulaw_code(w) : alaw_code(w);
        if (mdl_tx_high[it.channel]) r = '{BYTE_ZERO, code};
        else r = '{code, BYTE_ZERO};
      end
    end else begin
      if (mode == MODE_LINEAR) begin
        if (mdl_swap) r = '{it.second_byte, it.first_byte};
        else r = '{it.first_byte, it.second_byte};
      end else begin
        lin = (mode == MODE_ULAW) ? ulaw_linear(it.first_byte) : alaw_linear(it.first_byte);
        r = '{lin[7:0], lin[15:8]};
      end
    end
    return r;
  endfunction

  // Lean toward the sign and magnitude extremes
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hff;
      2: return 8'h7f;
      3: return 8'h80;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_item(input pcm_in_t it, input bit fixed, input pcm_out_t want);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_slots.push_back(fixed ? want : convert_sample(it));
    n_sent++;
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] data);
    in_valid <= 1'b0;
    while (pending_slots.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_CODEC_MODES: mdl_modes = data;
      REG_TX_HIGH:     mdl_tx_high = data[7:0];
      REG_RX_SWAP:     mdl_swap = data[0];
      default: ;
    endcase
    n_cfg++;
  endtask

  // Write only what differs; unused upper data bits get random values
  task automatic set_config(input logic [15:0] modes, input logic [7:0] high, input logic swap);
    if (modes !== mdl_modes) cfg_write(REG_CODEC_MODES, modes);
    if (high !== mdl_tx_high) cfg_write(REG_TX_HIGH, {8'($urandom), high});
    if (swap !== mdl_swap) cfg_write(REG_RX_SWAP, {15'($urandom), swap});
  endtask

  // Result checker
  initial begin
    pcm_out_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (pending_slots.size() == 0) begin
          $error("unexpected item: out_first_byte %h out_second_byte %h",
                 out_data.out_first_byte, out_data.out_second_byte);
          n_fail++;
        end else begin
          want = pending_slots.pop_front();
          if (out_data.out_first_byte !== want.out_first_byte) begin
            $error("out_first_byte: expected %h, got %h",
                   want.out_first_byte, out_data.out_first_byte);
            n_fail++;
          end
          if (out_data.out_second_byte !== want.out_second_byte) begin
            $error("out_second_byte: expected %h, got %h",
                   want.out_second_byte, out_data.out_second_byte);
            n_fail++;
          end
          n_checked++;
        end
      end
    end
  end

  // Output back-pressure, with one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_stall <= (!rst && $urandom_range(0, 99) < rx_idle_pct);
      end
    end
  end

  initial begin
    #800000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    dir_row_t rows [0:24];
    pcm_in_t it;
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_CODEC_MODES;
    cfg_data = '0;
    mdl_modes = '0;
    mdl_tx_high = '0;
    mdl_swap = 1'b0;
    hold_off_req = 1'b0;
    tx_idle_pct = 35;
    rx_idle_pct = 78;
    n_sent = 0;
    n_directed = 0;
    n_checked = 0;
    n_cfg = 0;
    n_fail = 0;

    rows = '{
      // straight after reset: everything linear
      '{16'h0000, 8'h00, 1'b0, '{ACT_TX, 3'd0, 8'h12, 8'h34}, 1'b1, '{8'h12, 8'h34}},
      '{16'h0000, 8'h00, 1'b0, '{ACT_RX, 3'd3, 8'hab, 8'hcd}, 1'b1, '{8'hab, 8'hcd}},
      '{16'h0000, 8'h00, 1'b0, '{ACT_TX, 3'd7, 8'hff, 8'hff}, 1'b1, '{8'hff, 8'hff}},
      '{16'h0000, 8'h00, 1'b0, '{ACT_RX, 3'd0, 8'h00, 8'h00}, 1'b1, '{8'h00, 8'h00}},
      // mu-law on all channels: zero, clipped extremes, decode ignores second byte
      '{16'h0055, 8'h00, 1'b0, '{ACT_TX, 3'd0, 8'h00, 8'h00}, 1'b1, '{8'hff, 8'h00}},
      '{16'h0055, 8'h00, 1'b0, '{ACT_TX, 3'd1, 8'hff, 8'h7f}, 1'b1, '{8'h80, 8'h00}},
      '{16'h0055, 8'h00, 1'b0, '{ACT_TX, 3'd2, 8'h00, 8'h80}, 1'b1, '{8'h00, 8'h00}},
      '{16'h0055, 8'h00, 1'b0, '{ACT_TX, 3'd3, 8'hff, 8'hff}, 1'b0, NO_WANT},
      '{16'h0055, 8'h00, 1'b0, '{ACT_RX, 3'd0, 8'hff, 8'hab}, 1'b1, '{8'h00, 8'h00}},
      '{16'h0055, 8'h00, 1'b0, '{ACT_RX, 3'd1, 8'h00, 8'h00}, 1'b1, '{8'h84, 8'h82}},
      '{16'h0055, 8'h00, 1'b0, '{ACT_RX, 3'd2, 8'h80, 8'h00}, 1'b1, '{8'h7c, 8'h7d}},
      '{16'h0055, 8'h00, 1'b0, '{ACT_TX, 3'd3, 8'h34, 8'h12}, 1'b0, NO_WANT},
      // A-law, code in the high byte, swap on; channels past the last stay linear
      '{16'h00aa, 8'hff, 1'b1, '{ACT_TX, 3'd0, 8'h00, 8'h00}, 1'b1, '{8'h00, 8'hd5}},
      '{16'h00aa, 8'hff, 1'b1, '{ACT_TX, 3'd1, 8'hff, 8'h7f}, 1'b1, '{8'h00, 8'haa}},
      '{16'h00aa, 8'hff, 1'b1, '{ACT_TX, 3'd2, 8'h00, 8'h80}, 1'b1, '{8'h00, 8'h2a}},
      '{16'h00aa, 8'hff, 1'b1, '{ACT_RX, 3'd3, 8'hd5, 8'h00}, 1'b1, '{8'h08, 8'h00}},
      '{16'h00aa, 8'hff, 1'b1, '{ACT_RX, 3'd0, 8'h55, 8'hff}, 1'b1, '{8'hf8, 8'hff}},
      '{16'h00aa, 8'hff, 1'b1, '{ACT_RX, 3'd1, 8'haa, 8'h12}, 1'b1, '{8'h00, 8'h7e}},
      '{16'h00aa, 8'hff, 1'b1, '{ACT_RX, 3'd4, 8'h12, 8'h34}, 1'b1, '{8'h34, 8'h12}},
      '{16'h00aa, 8'hff, 1'b1, '{ACT_TX, 3'd5, 8'h12, 8'h34}, 1'b1, '{8'h12, 8'h34}},
      // mode three everywhere behaves as A-law
      '{16'hffff, 8'hf0, 1'b0, '{ACT_TX, 3'd0, 8'h00, 8'h00}, 1'b1, '{8'hd5, 8'h00}},
      '{16'hffff, 8'hf0, 1'b0, '{ACT_RX, 3'd3, 8'h55, 8'h00}, 1'b1, '{8'hf8, 8'hff}},
      '{16'hffff, 8'hf0, 1'b0, '{ACT_RX, 3'd6, 8'h12, 8'h34}, 1'b1, '{8'h12, 8'h34}},
      '{16'hffff, 8'hf0, 1'b0, '{ACT_TX, 3'd7, 8'h12, 8'h34}, 1'b1, '{8'h12, 8'h34}},
      '{16'hffff, 8'hf0, 1'b0, '{ACT_TX, 3'd2, 8'h5a, 8'ha5}, 1'b0, NO_WANT}
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      set_config(rows[i].modes, rows[i].tx_high, rows[i].swap);
      send_item(rows[i].item, rows[i].fixed, rows[i].want);
      n_directed++;
    end

    // a write to the unused index must leave every register alone
    cfg_write(REG_UNUSED, 16'($urandom));

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin tx_idle_pct = 35; rx_idle_pct = 78; end
        1: begin tx_idle_pct = 78; rx_idle_pct = 35; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      for (int sg = 0; sg < 4; sg++) begin
        case (sg)
          0: set_config(16'h0000, 8'h00, 1'b0);
          1: set_config(16'hffff, 8'hff, 1'b1);
          default: set_config(16'($urandom), 8'($urandom), 1'($urandom));
        endcase
        // fill the pipeline against a stalled output
        if (ph == 2 && sg == 1) hold_off_req = 1'b1;
        repeat (RAND_PER_SETTING) begin
          it.action = 1'($urandom);
          it.channel = 3'($urandom);
          it.first_byte = pick_byte();
          it.second_byte = pick_byte();
          send_item(it, 1'b0, NO_WANT);
        end
      end
    end

    in_valid <= 1'b0;
    while (pending_slots.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d items sent (%0d directed), %0d results checked, %0d register writes",
             n_sent, n_directed, n_checked, n_cfg);
    $display("linear, mu-law, A-law and mode three in both directions, under idle, "
             , "stall and a long output hold-off");
    if (n_fail == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ g711_pcm_slot_converter.f @@
src/g711_pkg.sv
src/g711_pcm_slot_converter.sv
dv/g711_pcm_slot_converter_test.sv
